[src/lni_pkg.sv]
`default_nettype none
package lni_pkg;

  localparam logic [7:0] NL_BYTE    = 8'h0A;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] MINUS_BYTE = 8'h2D;
  localparam logic [7:0] ZERO_BYTE  = 8'h30;
  localparam int unsigned HOLD_DEPTH = 6;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_DELIMITER  = 3'd0,
    REG_MODES      = 3'd1,
    REG_STYLE      = 3'd2,
    REG_INCREMENT  = 3'd3,
    REG_BLANK_RUN  = 3'd4,
    REG_START      = 3'd5,
    REG_WIDTH      = 3'd6,
    REG_SEPARATOR  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_ALL      = 2'd0,
    MODE_NONEMPTY = 2'd1
  } mode_t;

  typedef enum logic [1:0] {
    STYLE_LEFT  = 2'd0,
    STYLE_RIGHT = 2'd1,
    STYLE_ZERO  = 2'd2
  } style_t;

  typedef struct packed {
    logic [15:0] delimiter_pair;
    logic [6:0]  section_modes;
    logic [1:0]  number_style;
    logic [31:0] increment;
    logic [15:0] blank_run;
    logic [31:0] start_number;
    logic [4:0]  field_width;
    logic [7:0]  separator_byte;
  } cfg_t;

  typedef struct packed {
    logic            pass;
    logic            num;
    logic [5:0][7:0] held;
    logic [2:0]      held_count;
    logic            has_byte;
    logic [7:0]      data;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_SIZE,
    B_PREFIX,
    B_SEP,
    B_HELD,
    B_BYTE
  } back_state_t;

endpackage
`default_nettype wire

[src/line_number_inserter.sv]
`default_nettype none
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------
// input    | in_valid / in_stall       | command, in_byte
// output   | out_valid / out_stall     | out_byte, last_of_run
// config   | cfg_write                 | cfg_index, cfg_data
//
// The front takes one request per cycle while its four-entry queue has room.
// Text inside a line leaves one byte per cycle while the output is not stalled. A line
// start first takes the job; when numbered, it converts the count from binary to
// decimal and sizes the field; then it emits the prefix, separator, held bytes and
// line byte in that order.
// Reset is synchronous and restores the configuration and control registers; data registers are not reset.
// A stalled output holds its byte while the front keeps accepting until the queue fills.
module line_number_inserter
  import lni_pkg::*;
#(
  parameter int MAX_WIDTH   = 16,
  parameter int NUMBER_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             last_of_run
);

  localparam int QW = $bits(job_t) + NUMBER_BITS;

  cfg_t                   cfg;
  logic                   accept, push, pop, full, empty, reload;
  job_t                   job_in, job_out;
  logic [NUMBER_BITS-1:0] count_in, count_out;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign reload   = cfg_write && cfg_reg_t'(cfg_index) == REG_START;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_pair <= 16'd23610;
      cfg.section_modes  <= 7'd102;
      cfg.number_style   <= 2'd1;
      cfg.increment      <= 32'd1;
      cfg.blank_run      <= 16'd1;
      cfg.start_number   <= 32'd1;
      cfg.field_width    <= 5'd6;
      cfg.separator_byte <= 8'd9;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DELIMITER: cfg.delimiter_pair <= cfg_data[15:0];
        REG_MODES:     cfg.section_modes  <= cfg_data[6:0];
        REG_STYLE:     cfg.number_style   <= cfg_data[1:0];
        REG_INCREMENT: cfg.increment      <= cfg_data;
        REG_BLANK_RUN: cfg.blank_run      <= cfg_data[15:0];
        REG_START:     cfg.start_number   <= cfg_data;
        REG_WIDTH:     cfg.field_width    <= cfg_data[4:0];
        REG_SEPARATOR: cfg.separator_byte <= cfg_data[7:0];
      endcase
    end
  end

  lni_front #(.NUMBER_BITS(NUMBER_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .reload      (reload),
    .reload_data (cfg_data),
    .accept      (accept),
    .command     (command),
    .in_byte     (in_byte),
    .push        (push),
    .job         (job_in),
    .job_count   (count_in)
  );

  lni_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({job_in, count_in}),
    .full  (full),
    .pop   (pop),
    .rdata ({job_out, count_out}),
    .empty (empty)
  );

  lni_back #(.MAX_WIDTH(MAX_WIDTH), .NUMBER_BITS(NUMBER_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .empty       (empty),
    .job         (job_out),
    .job_count   (count_out),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire

[src/lni_queue.sv]
`default_nettype none
module lni_queue
  import lni_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;

  assign full  = (count == (AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

[src/lni_front.sv]
`default_nettype none
module lni_front
  import lni_pkg::*;
#(
  parameter int NUMBER_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_t                   cfg,
  input  wire logic                   reload,
  input  wire logic [31:0]            reload_data,
  input  wire logic                   accept,
  input  wire logic                   command,
  input  wire logic [7:0]             in_byte,
  output logic                        push,
  output job_t                        job,
  output logic [NUMBER_BITS-1:0]      job_count
);

  logic [1:0]             current_section, current_section_next;
  logic [NUMBER_BITS-1:0] line_counter, line_counter_next;
  logic [15:0]            blank_count, blank_count_next;
  logic [5:0][7:0]        held_bytes, held_bytes_next;
  logic [2:0]             held_count, held_count_next;
  logic                   inside_line, inside_line_next;

  logic [NUMBER_BITS-1:0] inc_wide, start_wide, reload_wide;
  logic [7:0]  want;
  logic        is_nl, do_line, line_has, blank, num;
  logic [1:0]  mode;
  logic [15:0] blank_inc;

  generate
    if (NUMBER_BITS > 32) begin : g_wide
      assign inc_wide    = {{(NUMBER_BITS-32){cfg.increment[31]}}, cfg.increment};
      assign start_wide  = {{(NUMBER_BITS-32){cfg.start_number[31]}}, cfg.start_number};
      assign reload_wide = {{(NUMBER_BITS-32){reload_data[31]}}, reload_data};
    end else if (NUMBER_BITS == 32) begin : g_same
      assign inc_wide    = cfg.increment;
      assign start_wide  = cfg.start_number;
      assign reload_wide = reload_data;
    end else begin : g_narrow
      assign inc_wide    = cfg.increment[NUMBER_BITS-1:0];
      assign start_wide  = cfg.start_number[NUMBER_BITS-1:0];
      assign reload_wide = reload_data[NUMBER_BITS-1:0];
    end
  endgenerate

  always_comb begin
    current_section_next = current_section;
    line_counter_next    = line_counter;
    blank_count_next     = blank_count;
    held_bytes_next      = held_bytes;
    held_count_next      = held_count;
    inside_line_next     = inside_line;
    push      = 1'b0;
    do_line   = 1'b0;
    line_has  = 1'b0;
    blank     = 1'b0;
    num       = 1'b0;
    blank_inc = blank_count + 16'd1;
    is_nl     = (in_byte == NL_BYTE);
    want      = held_count[0] ? cfg.delimiter_pair[7:0] : cfg.delimiter_pair[15:8];
    unique case (current_section)
      2'd0:    mode = cfg.section_modes[1:0];
      2'd1:    mode = cfg.section_modes[3:2];
      default: mode = cfg.section_modes[5:4];
    endcase
    job.pass       = 1'b0;
    job.num        = 1'b0;
    job.held       = held_bytes;
    job.held_count = held_count;
    job.has_byte   = 1'b0;
    job.data       = in_byte;
    job_count      = line_counter;

    if (accept) begin
      if (command) begin
        if (!inside_line && held_count != 3'd0) begin
          do_line = 1'b1;
        end
        held_count_next  = 3'd0;
        inside_line_next = 1'b0;
      end else if (inside_line) begin
        push     = 1'b1;
        job.pass = 1'b1;
        if (is_nl) inside_line_next = 1'b0;
      end else if (is_nl && held_count >= 3'd2 && !held_count[0]) begin
        current_section_next = held_count[2:1] - 2'd1;
        blank_count_next     = 16'd0;
        if (cfg.section_modes[6]) line_counter_next = start_wide;
        held_count_next      = 3'd0;
      end else if (!is_nl && held_count < 3'(HOLD_DEPTH) && in_byte == want) begin
        held_bytes_next[held_count] = in_byte;
        held_count_next = held_count + 3'd1;
      end else begin
        do_line  = 1'b1;
        line_has = 1'b1;
      end
    end

    if (do_line) begin
      blank = line_has && held_count == 3'd0 && is_nl;
      priority case (mode)
        MODE_ALL: begin
          if (blank) begin
            if (blank_inc < cfg.blank_run) begin
              blank_count_next = blank_inc;
            end else begin
              num = 1'b1;
              blank_count_next = 16'd0;
            end
          end else begin
            num = 1'b1;
            blank_count_next = 16'd0;
          end
        end
        MODE_NONEMPTY: num = !blank;
        default:       num = 1'b0;
      endcase
      push         = 1'b1;
      job.num      = num;
      job.has_byte = line_has;
      if (num) line_counter_next = line_counter + inc_wide;
      held_count_next  = 3'd0;
      inside_line_next = line_has && !is_nl;
    end

    if (reload) line_counter_next = reload_wide;
  end

  always_ff @(posedge clk) begin
    held_bytes <= held_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_section <= 2'd1;
      line_counter    <= NUMBER_BITS'(1);
      blank_count     <= 16'd0;
      held_count      <= 3'd0;
      inside_line     <= 1'b0;
    end else begin
      current_section <= current_section_next;
      line_counter    <= line_counter_next;
      blank_count     <= blank_count_next;
      held_count      <= held_count_next;
      inside_line     <= inside_line_next;
    end
  end

endmodule
`default_nettype wire

[src/lni_back.sv]
`default_nettype none
module lni_back
  import lni_pkg::*;
#(
  parameter int MAX_WIDTH   = 16,
  parameter int NUMBER_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_t                   cfg,
  input  wire logic                   empty,
  input  wire job_t                   job,
  input  wire logic [NUMBER_BITS-1:0] job_count,
  output logic                        pop,
  input  wire logic                   out_stall,
  output logic                        out_valid,
  output logic [7:0]                  out_byte,
  output logic                        last_of_run
);

  localparam int ND   = (NUMBER_BITS * 3) / 10 + 1;
  localparam int FW_W = $clog2(MAX_WIDTH + 1);
  localparam int PW   = $clog2(ND + MAX_WIDTH + 2);
  localparam int CW   = $clog2(NUMBER_BITS);

  back_state_t state, state_next;

  logic [5:0][7:0]        held;
  logic [2:0]             held_count;
  logic                   has_byte;
  logic [7:0]             data;
  logic                   num;
  logic                   neg;
  logic [NUMBER_BITS-1:0] shreg;
  logic [ND*4-1:0]        bcd, bcd_adj;
  logic [CW-1:0]          cnt;
  logic [FW_W-1:0]        k;
  logic [2:0]             hi;
  logic [PW-1:0]          len, total, base;
  logic [PW-1:0]          nd_c, len_c, total_c, p, di;
  logic [3:0]             dig;
  logic [FW_W-1:0]        fw;
  logic                   can_load, emit, elast;
  logic [7:0]             ebyte, num_char;

  assign fw = (32'(cfg.field_width) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : FW_W'(cfg.field_width);
  assign can_load = !out_valid || !out_stall;

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_comb begin
    nd_c = PW'(1);
    for (int i = 1; i < ND; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) nd_c = PW'(i + 1);
    end
    len_c   = nd_c + PW'(neg);
    total_c = (len_c < PW'(fw)) ? PW'(fw) : len_c;
  end

  always_comb begin
    p  = base + PW'(k);
    di = (cfg.number_style == STYLE_LEFT) ? len - PW'(1) - p : total - PW'(1) - p;
    dig = bcd[di*4 +: 4];
    num_char = ZERO_BYTE | {4'd0, dig};
    priority case (cfg.number_style)
      STYLE_LEFT: begin
        if (p < PW'(neg)) ebyte = MINUS_BYTE;
        else if (p < len) ebyte = num_char;
        else ebyte = SPACE_BYTE;
      end
      STYLE_ZERO: begin
        if (neg && p == '0) ebyte = MINUS_BYTE;
        else if (p < PW'(neg) + total - len) ebyte = ZERO_BYTE;
        else ebyte = num_char;
      end
      default: begin
        if (p < total - len) ebyte = SPACE_BYTE;
        else if (neg && p == total - len) ebyte = MINUS_BYTE;
        else ebyte = num_char;
      end
    endcase
    if (!num) ebyte = SPACE_BYTE;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!empty && !job.pass) begin
          if (job.num) state_next = B_CONV;
          else if (fw != '0) state_next = B_PREFIX;
          else state_next = B_SEP;
        end
      end
      B_CONV: begin
        if (cnt == CW'(NUMBER_BITS - 1)) state_next = B_SIZE;
      end
      B_SIZE: begin
        state_next = (fw != '0) ? B_PREFIX : B_SEP;
      end
      B_PREFIX: begin
        if (can_load && k == fw - FW_W'(1)) state_next = B_SEP;
      end
      B_SEP: begin
        if (can_load) begin
          if (held_count != 3'd0) state_next = B_HELD;
          else if (has_byte) state_next = B_BYTE;
          else state_next = B_IDLE;
        end
      end
      B_HELD: begin
        if (can_load && hi == held_count - 3'd1) state_next = has_byte ? B_BYTE : B_IDLE;
      end
      B_BYTE: begin
        if (can_load) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    emit  = 1'b0;
    elast = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!empty) begin
          if (job.pass) begin
            pop   = can_load;
            emit  = can_load;
            elast = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end
      end
      B_PREFIX: emit = can_load;
      B_SEP: begin
        emit  = can_load;
        elast = (held_count == 3'd0) && !has_byte;
      end
      B_HELD: begin
        emit  = can_load;
        elast = (hi == held_count - 3'd1) && !has_byte;
      end
      B_BYTE: begin
        emit  = can_load;
        elast = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        held       <= job.held;
        held_count <= job.held_count;
        has_byte   <= job.has_byte;
        data       <= job.data;
        num        <= job.num;
        neg        <= job_count[NUMBER_BITS-1];
        shreg      <= job_count[NUMBER_BITS-1] ? -job_count : job_count;
        bcd        <= '0;
        cnt        <= '0;
        k          <= '0;
        hi         <= 3'd0;
        len        <= '0;
        total      <= PW'(fw);
        base       <= '0;
      end
      B_CONV: begin
        bcd   <= {bcd_adj[ND*4-2:0], shreg[NUMBER_BITS-1]};
        shreg <= {shreg[NUMBER_BITS-2:0], 1'b0};
        cnt   <= cnt + CW'(1);
      end
      B_SIZE: begin
        len   <= len_c;
        total <= total_c;
        base  <= total_c - PW'(fw);
      end
      B_PREFIX: if (can_load) k <= k + FW_W'(1);
      B_HELD:   if (can_load) hi <= hi + 3'd1;
      default: ;
    endcase
    if (emit) begin
      unique case (state)
        B_IDLE:   out_byte <= job.data;
        B_PREFIX: out_byte <= ebyte;
        B_SEP:    out_byte <= cfg.separator_byte;
        B_HELD:   out_byte <= held[hi];
        default:  out_byte <= data;
      endcase
      last_of_run <= elast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (can_load) out_valid <= emit;
    end
  end

endmodule
`default_nettype wire

[tb/lni_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
module lni_checker
  import lni_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        command,
  input  wire logic [7:0]  in_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  out_byte,
  input  wire logic        last_of_run,
  output int               errors,
  output int               pending,
  output int               bytes_checked,
  output int               lines_numbered
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  text_byte_t text_q[$];

  logic [15:0] delim;
  logic [6:0]  modes;
  logic [1:0]  style;
  logic [31:0] incr;
  logic [15:0] run_len;
  logic [31:0] start_val;
  logic [4:0]  width;
  logic [7:0]  sep;

  logic [1:0]  section;
  logic [31:0] counter;
  logic [15:0] blanks;
  logic [7:0]  held [HOLD_DEPTH];
  int          held_n;
  bit          in_line;

  initial begin
    errors = 0;
    bytes_checked = 0;
    lines_numbered = 0;
  end

  task automatic emit(input logic [7:0] b);
    text_q.push_back('{data: b, last: 1'b0});
  endtask

  task automatic emit_number(input int fw);
    logic [7:0] digits[$];
    logic [7:0] field[$];
    logic [31:0] mag;
    bit neg;
    int len;
    int total;
    neg = counter[31];
    mag = neg ? -counter : counter;
    do begin
      digits.push_back(ZERO_BYTE + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    len = digits.size() + (neg ? 1 : 0);
    total = (len < fw) ? fw : len;
    if (style == STYLE_LEFT) begin
      if (neg) field.push_back(MINUS_BYTE);
      while (digits.size() > 0) field.push_back(digits.pop_back());
      while (field.size() < total) field.push_back(SPACE_BYTE);
    end else if (style == STYLE_ZERO) begin
      if (neg) field.push_back(MINUS_BYTE);
      for (int i = len; i < total; i++) field.push_back(ZERO_BYTE);
      while (digits.size() > 0) field.push_back(digits.pop_back());
    end else begin
      for (int i = len; i < total; i++) field.push_back(SPACE_BYTE);
      if (neg) field.push_back(MINUS_BYTE);
      while (digits.size() > 0) field.push_back(digits.pop_back());
    end
    for (int i = total - fw; i < total; i++) emit(field[i]);
  endtask

  task automatic open_line(input bit has_byte, input logic [7:0] b);
    int fw;
    bit blank;
    bit numbered;
    logic [1:0] mode;
    fw = (width > 16) ? 16 : int'(width);
    blank = has_byte && held_n == 0 && b == NL_BYTE;
    mode = 2'(modes >> (2 * section));
    if (mode == MODE_ALL) begin
      if (blank) begin
        blanks = blanks + 1;
        numbered = blanks >= run_len;
        if (numbered) blanks = 0;
      end else begin
        numbered = 1;
        blanks = 0;
      end
    end else if (mode == MODE_NONEMPTY) begin
      numbered = !blank;
    end else begin
      numbered = 0;
    end
    if (numbered) begin
      emit_number(fw);
      counter = counter + incr;
      lines_numbered++;
    end else begin
      for (int i = 0; i < fw; i++) emit(SPACE_BYTE);
    end
    emit(sep);
    for (int i = 0; i < held_n; i++) emit(held[i]);
    if (has_byte) emit(b);
    held_n = 0;
    in_line = has_byte && b != NL_BYTE;
  endtask

  task automatic take_request(input logic cmd, input logic [7:0] b);
    int before_n;
    logic [7:0] want;
    text_byte_t tail;
    before_n = text_q.size();
    if (cmd) begin
      if (!in_line && held_n > 0) open_line(0, 8'h00);
      held_n = 0;
      in_line = 0;
    end else if (in_line) begin
      emit(b);
      if (b == NL_BYTE) in_line = 0;
    end else begin
      want = held_n[0] ? delim[7:0] : delim[15:8];
      if (b == NL_BYTE && held_n >= 2 && !held_n[0]) begin
        section = 2'(held_n / 2 - 1);
        blanks = 0;
        if (modes[6]) counter = start_val;
        held_n = 0;
      end else if (b != NL_BYTE && held_n < HOLD_DEPTH && b == want) begin
        held[held_n] = b;
        held_n++;
      end else begin
        open_line(1, b);
      end
    end
    if (text_q.size() > before_n) begin
      tail = text_q.pop_back();
      tail.last = 1'b1;
      text_q.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    text_byte_t exp_b;
    if (rst) begin
      text_q.delete();
      delim = 16'd23610;
      modes = 7'd102;
      style = STYLE_RIGHT;
      incr = 32'd1;
      run_len = 16'd1;
      start_val = 32'd1;
      width = 5'd6;
      sep = 8'd9;
      section = 2'd1;
      counter = 32'd1;
      blanks = '0;
      held_n = 0;
      in_line = 0;
    end else begin
      if (out_valid && !out_stall) begin
        bytes_checked++;
        if (text_q.size() == 0) begin
          $error("unexpected output byte %h", out_byte);
          errors++;
        end else begin
          exp_b = text_q.pop_front();
          if (out_byte !== exp_b.data) begin
            $error("out_byte expected %h actual %h", exp_b.data, out_byte);
            errors++;
          end
          if (last_of_run !== exp_b.last) begin
            $error("last_of_run expected %b actual %b", exp_b.last, last_of_run);
            errors++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_DELIMITER: delim = cfg_data[15:0];
          REG_MODES:     modes = cfg_data[6:0];
          REG_STYLE:     style = cfg_data[1:0];
          REG_INCREMENT: incr = cfg_data;
          REG_BLANK_RUN: run_len = cfg_data[15:0];
          REG_START: begin
            start_val = cfg_data;
            counter = cfg_data;
          end
          REG_WIDTH:     width = cfg_data[4:0];
          REG_SEPARATOR: sep = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_request(command, in_byte);
    end
    pending <= text_q.size();
  end

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import lni_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT = 5000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_write = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        command = 0;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  out_byte;
  logic        last_of_run;

  int errors, pending, bytes_checked, lines_numbered;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_cycles = 0;
  int requests_sent = 0;
  int quiet_cycles = 0;
  logic [15:0] cur_delim = 16'd23610;

  line_number_inserter u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .last_of_run(last_of_run)
  );

  lni_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .last_of_run(last_of_run),
    .errors(errors), .pending(pending),
    .bytes_checked(bytes_checked), .lines_numbered(lines_numbered)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic cmd, input logic [7:0] b);
    in_valid <= 1'b1;
    command <= cmd;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] dp, input logic [6:0] md,
                               input logic [1:0] st, input logic [31:0] inc,
                               input logic [15:0] br, input logic [31:0] sn,
                               input logic [4:0] fw, input logic [7:0] sp);
    drain();
    write_reg(REG_DELIMITER, {16'd0, dp});
    write_reg(REG_MODES, {25'd0, md});
    write_reg(REG_STYLE, {30'd0, st});
    write_reg(REG_INCREMENT, inc);
    write_reg(REG_BLANK_RUN, {16'd0, br});
    write_reg(REG_START, sn);
    write_reg(REG_WIDTH, {27'd0, fw});
    write_reg(REG_SEPARATOR, {24'd0, sp});
    cur_delim = dp;
  endtask

  task automatic send_pairs(input int count);
    for (int i = 0; i < count; i++) send(0, i[0] ? cur_delim[7:0] : cur_delim[15:8]);
  endtask

  task automatic send_sequence();
    int kind;
    int len;
    kind = $urandom_range(99);
    if (kind < 40) begin
      len = $urandom_range(10);
      if ($urandom_range(3) == 0) send_pairs($urandom_range(5));
      for (int i = 0; i < len; i++) send(0, 8'($urandom_range(255)));
      send(0, NL_BYTE);
    end else if (kind < 55) begin
      send(0, NL_BYTE);
    end else if (kind < 75) begin
      send_pairs(2 * $urandom_range(1, 3));
      send(0, NL_BYTE);
    end else if (kind < 88) begin
      send_pairs($urandom_range(1, 7));
      if ($urandom_range(1)) send(0, 8'($urandom_range(255)));
      else send(0, NL_BYTE);
    end else if (kind < 95) begin
      send_pairs($urandom_range(4));
      send(1, 8'($urandom_range(255)));
    end else begin
      send(1'($urandom_range(1)), 8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int idle_mode, input int count);
    int start_n;
    case (idle_mode % 4)
      0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      1: begin sender_idle_pct = 73; receiver_stall_pct = 0; end
      2: begin sender_idle_pct = 0; receiver_stall_pct = 73; end
      default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
    endcase
    start_n = requests_sent;
    while (requests_sent - start_n < count) send_sequence();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pairs(6);
    send(0, NL_BYTE);
    send(0, "a");
    send(0, NL_BYTE);
    send(0, NL_BYTE);
    send(0, NL_BYTE);
    send_pairs(2);
    send(0, NL_BYTE);
    send_pairs(3);
    send(0, NL_BYTE);
    send_pairs(4);
    send(0, NL_BYTE);
    send_pairs(7);
    send(0, 8'h00);
    send(0, 8'hFF);
    send(0, NL_BYTE);
    send_pairs(2);
    send(1, 8'hFF);
    send(1, 8'h00);

    apply_setting(16'h5C3A, 7'h52, STYLE_LEFT, 32'd1, 16'd2, 32'h7FFF_FFFE, 5'd16, 8'h7C);
    run_phase(0, 50);
    apply_setting(16'h0A3A, 7'h00, STYLE_ZERO, 32'h8000_0000, 16'd0, 32'h8000_0000,
                  5'd1, 8'h00);
    run_phase(1, 50);
    apply_setting(16'hFFFF, 7'h15, 2'd3, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 5'd31, 8'hFF);
    hold_cycles = 400;
    run_phase(2, 25);
    drain();
    run_phase(2, 25);
    apply_setting(16'h0000, 7'h7F, STYLE_RIGHT, 32'd7, 16'd3, 32'hFFFF_FFFB, 5'd0, 8'h09);
    run_phase(3, 50);
    apply_setting(16'h2D2D, 7'h40, STYLE_LEFT, 32'h7FFF_FFFF, 16'd1, 32'h8000_0001,
                  5'd11, ":");
    run_phase(0, 50);
    apply_setting(16'd23610, 7'd102, STYLE_RIGHT, 32'd1, 16'd1, 32'd1, 5'd6, 8'd9);
    run_phase(3, 50);

    drain();
    $display("Sent %0d requests under the reset setting, six written settings and four idle patterns.",
             requests_sent);
    $display("Checked %0d output bytes, %0d numbered lines.", bytes_checked, lines_numbered);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
